// ===== rtl/ksmp_pkg.sv =====
// ksmp_pkg: shared types and constants for the scalar keyframe sampler
// beat structs for the request and response channels, command and register codes
// no dependencies
`timescale 1ns / 1ps

package ksmp_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = 6;
  localparam int CFG_DW   = 7;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [1:0] REG_MODE      = 2'd1;
  localparam logic [1:0] REG_TANGENTS  = 2'd2;

  localparam logic [1:0] MODE_STEP    = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_HERMITE = 2'd2;

  typedef struct packed {
    logic                     command;
    logic [KEY_AW-1:0]        key_index;
    logic signed [31:0]       key_time;
    logic signed [31:0]       key_value;
    logic signed [31:0]       key_in_tangent;
    logic signed [31:0]       key_out_tangent;
    logic signed [31:0]       sample_time;
  } req_t;

  typedef struct packed {
    logic signed [31:0]       sample_value;
    logic                     clamped;
    logic [KEY_AW-1:0]        segment_index;
  } rsp_t;

endpackage

// ===== rtl/scalar_keyframe_sampler.sv =====
// scalar_keyframe_sampler: top level, key tables, search sequencer, divider and
// one shared 18x34 multiplier; depends on ksmp_pkg
`timescale 1ns / 1ps

// Usage
//  req channel (req_valid / req_stall / req): one beat is a load or a sample.
//  A load writes one key into the four tables; the sequencer stays idle.
//  A sample finds the segment around sample_time with a binary search over
//  the time table and, unless in step mode, divides for the fraction and then
//  runs the interpolation on one shared multiplier; one rsp beat comes out
//  per sample. A clamped sample skips the search and the divider, and step
//  mode skips the divider and the multiplier. The divider makes one bit a
//  cycle; it and the single table read port set how long a sample takes.
//  req_stall stays high while a sample is in flight and while its result
//  waits on rsp.
//  cfg port: cfg_write, cfg_index, cfg_data; write only while idle.
//  Reset (rst, synchronous) clears the sequencer and sets key_count 0,
//  interp_mode linear, tangents_present 0; tables are undefined until loaded.
//  A stalled rsp beat holds its value until taken.
module scalar_keyframe_sampler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  ksmp_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output ksmp_pkg::rsp_t              rsp,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [ksmp_pkg::CFG_DW-1:0] cfg_data
);

  localparam int AW = ksmp_pkg::KEY_AW;

  localparam logic [3:0] OP_FF     = 4'd0;
  localparam logic [3:0] OP_M0_LO  = 4'd1;
  localparam logic [3:0] OP_T3     = 4'd2;
  localparam logic [3:0] OP_M0_HI  = 4'd3;
  localparam logic [3:0] OP_M1_LO  = 4'd4;
  localparam logic [3:0] OP_M1_HI  = 4'd5;
  localparam logic [3:0] OP_H00    = 4'd6;
  localparam logic [3:0] OP_H01    = 4'd7;
  localparam logic [3:0] OP_H10_LO = 4'd8;
  localparam logic [3:0] OP_H10_HI = 4'd9;
  localparam logic [3:0] OP_H11_LO = 4'd10;
  localparam logic [3:0] OP_H11_HI = 4'd11;
  localparam logic [3:0] OP_LIN    = 4'd12;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHKF  = 11'b000_0000_0010,
    S_CHKL  = 11'b000_0000_0100,
    S_PROBE = 11'b000_0000_1000,
    S_CMP   = 11'b000_0001_0000,
    S_RDLO  = 11'b000_0010_0000,
    S_RDHI  = 11'b000_0100_0000,
    S_CAPHI = 11'b000_1000_0000,
    S_DIV   = 11'b001_0000_0000,
    S_MUL   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [6:0] key_count;
  logic [1:0] interp_mode;
  logic       tangents_present;

  // key tables
  logic signed [31:0] time_mem  [ksmp_pkg::MAX_KEYS];
  logic signed [31:0] value_mem [ksmp_pkg::MAX_KEYS];
  logic signed [31:0] itan_mem  [ksmp_pkg::MAX_KEYS];
  logic signed [31:0] otan_mem  [ksmp_pkg::MAX_KEYS];
  logic signed [31:0] time_rd, value_rd, itan_rd, otan_rd;
  logic [AW-1:0]      rd_addr;

  // sample working registers
  logic signed [31:0] t;
  logic [6:0]         n;
  logic [AW-1:0]      lo, hi, last;
  logic signed [31:0] tlo, a, b, otan, itan;
  logic [32:0]        span;
  logic [33:0]        rem;
  logic [15:0]        frac;
  logic [4:0]         div_cnt;
  logic [15:0]        t2, t3;
  logic signed [48:0] m0, m1;
  logic signed [51:0] part;
  logic signed [63:0] acc;
  logic [3:0]         op, op_last, p_op;
  logic               issue_done, p_valid;
  logic signed [51:0] prod;
  ksmp_pkg::rsp_t     res;

  logic               accept;
  logic [AW:0]        mid_sum;
  logic [AW-1:0]      mid;
  logic [33:0]        rem2;
  logic signed [18:0] h00, h01, h10, h11;
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [32:0] diff_ba;
  logic signed [79:0] wide_term;
  logic               hermite;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign rsp       = res;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[AW:1];
  assign rem2    = {rem[32:0], 1'b0};
  assign hermite = (interp_mode == ksmp_pkg::MODE_HERMITE) && tangents_present;

  // hermite basis from frac, t2, t3
  assign h00 = 19'sd65536 + $signed({2'b0, t3, 1'b0})
             - $signed({3'b0, t2}) - $signed({2'b0, t2, 1'b0});
  assign h10 = $signed({3'b0, t3}) - $signed({2'b0, t2, 1'b0}) + $signed({3'b0, frac});
  assign h01 = $signed({3'b0, t2}) + $signed({2'b0, t2, 1'b0}) - $signed({2'b0, t3, 1'b0});
  assign h11 = $signed({3'b0, t3}) - $signed({3'b0, t2});
  assign diff_ba = $signed({b[31], b}) - $signed({a[31], a});

  // table read address
  always_comb begin
    unique case (state)
      S_CHKF:  rd_addr = last;
      S_PROBE: rd_addr = mid;
      S_RDLO:  rd_addr = lo;
      S_RDHI:  rd_addr = hi;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && req.command == ksmp_pkg::CMD_LOAD) begin
      time_mem[req.key_index]  <= req.key_time;
      value_mem[req.key_index] <= req.key_value;
      itan_mem[req.key_index]  <= req.key_in_tangent;
      otan_mem[req.key_index]  <= req.key_out_tangent;
    end
    time_rd  <= time_mem[rd_addr];
    value_rd <= value_mem[rd_addr];
    itan_rd  <= itan_mem[rd_addr];
    otan_rd  <= otan_mem[rd_addr];
  end

  // shared multiplier operand select
  always_comb begin
    unique case (op)
      OP_FF:     begin mul_a = {2'b0, frac};                 mul_b = {18'b0, frac}; end
      OP_M0_LO:  begin mul_a = {2'b0, otan[15:0]};           mul_b = {1'b0, span}; end
      OP_T3:     begin mul_a = {2'b0, t2};                   mul_b = {18'b0, frac}; end
      OP_M0_HI:  begin mul_a = {{2{otan[31]}}, otan[31:16]}; mul_b = {1'b0, span}; end
      OP_M1_LO:  begin mul_a = {2'b0, itan[15:0]};           mul_b = {1'b0, span}; end
      OP_M1_HI:  begin mul_a = {{2{itan[31]}}, itan[31:16]}; mul_b = {1'b0, span}; end
      OP_H00:    begin mul_a = h00[17:0];                    mul_b = {{2{a[31]}}, a}; end
      OP_H01:    begin mul_a = h01[17:0];                    mul_b = {{2{b[31]}}, b}; end
      OP_H10_LO: begin mul_a = h10[17:0];                    mul_b = {10'b0, m0[23:0]}; end
      OP_H10_HI: begin mul_a = h10[17:0];                    mul_b = {{9{m0[48]}}, m0[48:24]}; end
      OP_H11_LO: begin mul_a = h11[17:0];                    mul_b = {10'b0, m1[23:0]}; end
      OP_H11_HI: begin mul_a = h11[17:0];                    mul_b = {{9{m1[48]}}, m1[48:24]}; end
      default:   begin mul_a = {2'b0, frac};                 mul_b = {diff_ba[32], diff_ba}; end
    endcase
  end

  // split products recombined before the floor shift
  assign wide_term = $signed({{28{part[51]}}, part}) + $signed({{4{prod[51]}}, prod, 24'b0});

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && req.command == ksmp_pkg::CMD_SAMPLE) begin
          if (key_count == 7'd0) state_next = S_OUT;
          else                   state_next = S_CHKF;
        end
      end
      S_CHKF: begin
        if (n == 7'd1 || t <= time_rd) state_next = S_OUT;
        else                           state_next = S_CHKL;
      end
      S_CHKL: begin
        if (t >= time_rd)          state_next = S_OUT;
        else if (last == AW'(1))   state_next = S_RDLO;
        else                       state_next = S_PROBE;
      end
      S_PROBE: state_next = S_CMP;
      S_CMP: begin
        if (time_rd <= t) state_next = (hi - mid > AW'(1)) ? S_PROBE : S_RDLO;
        else              state_next = (mid - lo > AW'(1)) ? S_PROBE : S_RDLO;
      end
      S_RDLO:  state_next = S_RDHI;
      S_RDHI:  state_next = S_CAPHI;
      S_CAPHI: begin
        if (interp_mode == ksmp_pkg::MODE_STEP) state_next = S_OUT;
        else                                    state_next = S_DIV;
      end
      S_DIV: begin
        if (div_cnt == 5'd15) state_next = S_MUL;
      end
      S_MUL: begin
        // all products issued and the last one accumulated
        if (issue_done && !p_valid) state_next = S_OUT;
      end
      S_OUT: begin
        if (!rsp_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      key_count        <= '0;
      interp_mode      <= ksmp_pkg::MODE_LINEAR;
      tangents_present <= 1'b0;
      p_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          ksmp_pkg::REG_KEY_COUNT: key_count        <= cfg_data;
          ksmp_pkg::REG_MODE:      interp_mode      <= cfg_data[1:0];
          ksmp_pkg::REG_TANGENTS:  tangents_present <= cfg_data[0];
          default: ;
        endcase
      end
      p_valid <= (state == S_MUL) && !issue_done;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    p_op <= op;
    unique case (state)
      S_IDLE: begin
        t    <= req.sample_time;
        n    <= (key_count > 7'(ksmp_pkg::MAX_KEYS)) ? 7'(ksmp_pkg::MAX_KEYS) : key_count;
        last <= (key_count > 7'(ksmp_pkg::MAX_KEYS)) ? AW'(ksmp_pkg::MAX_KEYS - 1)
                                                     : AW'(key_count - 7'd1);
        res  <= '{sample_value: '0, clamped: 1'b1, segment_index: '0};
      end
      S_CHKF: begin
        res <= '{sample_value: value_rd, clamped: 1'b1, segment_index: '0};
        lo  <= '0;
        hi  <= last;
      end
      S_CHKL: res <= '{sample_value: value_rd, clamped: 1'b1, segment_index: last};
      S_CMP: begin
        if (time_rd <= t) lo <= mid;
        else              hi <= mid;
      end
      S_RDHI: begin
        tlo  <= time_rd;
        a    <= value_rd;
        otan <= otan_rd;
      end
      S_CAPHI: begin
        b       <= value_rd;
        itan    <= itan_rd;
        span    <= 33'($signed({time_rd[31], time_rd}) - $signed({tlo[31], tlo}));
        rem     <= {1'b0, 33'($signed({t[31], t}) - $signed({tlo[31], tlo}))};
        div_cnt <= '0;
        res     <= '{sample_value: a, clamped: 1'b0, segment_index: lo};
      end
      S_DIV: begin
        div_cnt <= div_cnt + 5'd1;
        if (rem2 >= {1'b0, span}) begin
          rem  <= rem2 - {1'b0, span};
          frac <= {frac[14:0], 1'b1};
        end else begin
          rem  <= rem2;
          frac <= {frac[14:0], 1'b0};
        end
        op         <= hermite ? OP_FF : OP_LIN;
        op_last    <= hermite ? OP_H11_HI : OP_LIN;
        issue_done <= 1'b0;
        acc        <= '0;
      end
      S_MUL: begin
        if (!issue_done) begin
          if (op == op_last) issue_done <= 1'b1;
          else               op <= op + 4'd1;
        end
        if (p_valid) begin
          unique case (p_op)
            OP_FF:     t2 <= prod[31:16];
            OP_T3:     t3 <= prod[31:16];
            OP_M0_LO:  m0 <= {{13{prod[51]}}, prod[51:16]};
            OP_M0_HI:  m0 <= m0 + prod[48:0];
            OP_M1_LO:  m1 <= {{13{prod[51]}}, prod[51:16]};
            OP_M1_HI:  m1 <= m1 + prod[48:0];
            OP_H00, OP_H01: acc <= acc + {{28{prod[51]}}, prod[51:16]};
            OP_H10_LO, OP_H11_LO: part <= prod;
            OP_H10_HI, OP_H11_HI: acc <= acc + wide_term[79:16];
            default:   acc <= {{32{a[31]}}, a} + {{28{prod[51]}}, prod[51:16]};
          endcase
        end
      end
      default: ;
    endcase
    if (state == S_MUL && state_next == S_OUT) begin
      // saturate to 32 bits; acc already holds the full sum
      res.sample_value <= (acc > 64'sd2147483647)  ? 32'sh7fffffff :
                          (acc < -64'sd2147483648) ? 32'sh80000000 : acc[31:0];
    end
  end

`ifndef SYNTHESIS
  a_rsp_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall) else $error("request taken while a result waits");

  a_div_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < {1'b0, span})) else $error("divider remainder out of range");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == ksmp_pkg::CMD_LOAD) |=> !req_stall)
    else $error("load left the sequencer busy");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (hi > lo + AW'(1))) else $error("search bounds collapsed");
`endif

endmodule
